FILE: src/gpuf_pkg.sv
// ----------------------------------------------------------------------------
// gpuf_pkg
// Shared constants, command and status types for the percolation grid with
// weighted union-find.
// ----------------------------------------------------------------------------
`default_nettype none

package gpuf_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = 7;
  localparam int IDX_W      = $clog2(MAX_SIDE);
  localparam int SITE_COUNT = MAX_SIDE * MAX_SIDE;
  localparam int SITE_W     = $clog2(SITE_COUNT);
  localparam int NODE_COUNT = SITE_COUNT + 2;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = 13;
  localparam int SIZE_W     = NODE_W;

  localparam logic [NODE_W-1:0] NODE_TOP    = NODE_W'(SITE_COUNT);
  localparam logic [NODE_W-1:0] NODE_BOTTOM = NODE_W'(SITE_COUNT + 1);
  localparam logic [NODE_W-1:0] NODE_LAST   = NODE_W'(NODE_COUNT - 1);

  localparam logic FUNC_OPEN  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LATCH,
    DP_CLR_STEP,
    DP_RD_OPEN_HERE,
    DP_RD_OPEN_NB,
    DP_SET_OPEN,
    DP_FIND_START,
    DP_FIND_WALK,
    DP_LINK_LOSER,
    DP_LINK_WINNER,
    DP_CAP_OPEN,
    DP_CAP_FULL,
    DP_CAP_PERC
  } dp_op_t;

  typedef enum logic [1:0] {
    OPND_HERE,
    OPND_TOP,
    OPND_BOTTOM,
    OPND_NB
  } opnd_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  typedef enum logic {
    SLOT_A,
    SLOT_B
  } slot_t;

  typedef struct packed {
    dp_op_t op;
    opnd_t  sel;
    slot_t  dst;
    dir_t   dir;
  } dp_cmd_t;

  typedef struct packed {
    logic       bad;
    logic       func;
    logic       open_rd;
    logic       root_hit;
    logic       same_root;
    logic       row_top;
    logic       row_bot;
    logic [3:0] nb_valid;
    logic       clr_done;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/grid_percolation_union_find.sv
// ----------------------------------------------------------------------------
// grid_percolation_union_find
// Percolation grid with a weighted quick-union forest over the sites plus a
// virtual top and bottom node.
//
//   channel   ports                                          handshake
//   request   in_func in_row in_col                          start & !busy
//   result    out_site_open out_site_full out_open_total     out_valid, 1 cycle
//             out_does_percolate out_bad_index
//   config    cfg_grid_side                                  cfg_we
//
// A query runs three closing finds before its result; a find walks one node
// per cycle from its start to the root, as the node memory read port sets the
// walk rate. A bad index runs two finds. An open of a blocked site adds a slot
// scan with a neighbor read per in-grid neighbor, and per union two finds, a
// root compare and a link, with up to four unions. After reset and after each
// config write, a clearing pass over every node holds busy high.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_percolation_union_find (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_func,
  input  wire logic [gpuf_pkg::IDX_W-1:0]   in_row,
  input  wire logic [gpuf_pkg::IDX_W-1:0]   in_col,
  output logic                              out_valid,
  output logic                              out_site_open,
  output logic                              out_site_full,
  output logic [gpuf_pkg::CNT_W-1:0]        out_open_total,
  output logic                              out_does_percolate,
  output logic                              out_bad_index,
  input  wire logic                         cfg_we,
  input  wire logic [gpuf_pkg::SIDE_W-1:0]  cfg_grid_side
);

  import gpuf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gpuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  gpuf_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (in_func),
    .in_row             (in_row),
    .in_col             (in_col),
    .cfg_we             (cfg_we),
    .cfg_grid_side      (cfg_grid_side),
    .out_site_open      (out_site_open),
    .out_site_full      (out_site_full),
    .out_open_total     (out_open_total),
    .out_does_percolate (out_does_percolate),
    .out_bad_index      (out_bad_index)
  );

endmodule

`default_nettype wire

FILE: src/gpuf_ram.sv
// ----------------------------------------------------------------------------
// gpuf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gpuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/gpuf_datapath.sv
// ----------------------------------------------------------------------------
// gpuf_datapath
// Site map, union-find node store, find walker, link logic and result
// registers, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module gpuf_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gpuf_pkg::dp_cmd_t         cmd,
  output gpuf_pkg::dp_stat_t             stat,
  input  wire logic                      in_func,
  input  wire logic [gpuf_pkg::IDX_W-1:0] in_row,
  input  wire logic [gpuf_pkg::IDX_W-1:0] in_col,
  input  wire logic                      cfg_we,
  input  wire logic [gpuf_pkg::SIDE_W-1:0] cfg_grid_side,
  output logic                           out_site_open,
  output logic                           out_site_full,
  output logic [gpuf_pkg::CNT_W-1:0]     out_open_total,
  output logic                           out_does_percolate,
  output logic                           out_bad_index
);

  import gpuf_pkg::*;

  localparam int ENT_W = NODE_W + SIZE_W;

  logic [SIDE_W-1:0] side_r, side_use;
  logic              func_r, func_r_nxt;
  logic [IDX_W-1:0]  row_r, row_r_nxt, col_r, col_r_nxt;
  logic              bad_r, bad_r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_r_nxt;
  logic [NODE_W-1:0] clr_r, clr_r_nxt;
  logic [NODE_W-1:0] node_r, node_r_nxt;
  logic [NODE_W-1:0] ra_r, ra_r_nxt, rb_r, rb_r_nxt;
  logic [SIZE_W-1:0] sza_r, sza_r_nxt, szb_r, szb_r_nxt;
  logic              open_r, open_r_nxt, full_r, full_r_nxt, perc_r, perc_r_nxt;

  logic [SITE_W-1:0] here, nb;
  logic [NODE_W-1:0] opnd;
  logic [NODE_W-1:0] par_rd;
  logic [SIZE_W-1:0] sz_rd;
  logic              a_smaller;
  logic [NODE_W-1:0] winner, loser;
  logic [SIZE_W-1:0] loser_sz;

  logic              om_we, om_wdata, om_rdata;
  logic [SITE_W-1:0] om_waddr, om_raddr;
  logic              nd_we;
  logic [NODE_W-1:0] nd_waddr, nd_raddr;
  logic [ENT_W-1:0]  nd_wdata, nd_rdata;

  gpuf_ram #(.WIDTH(1), .DEPTH(SITE_COUNT)) u_open_map (
    .clk   (clk),
    .we    (om_we),
    .waddr (om_waddr),
    .wdata (om_wdata),
    .raddr (om_raddr),
    .rdata (om_rdata)
  );

  gpuf_ram #(.WIDTH(ENT_W), .DEPTH(NODE_COUNT)) u_nodes (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  assign side_use = (side_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_r;
  assign here     = SITE_W'({row_r, col_r});
  assign par_rd   = nd_rdata[ENT_W-1:SIZE_W];
  assign sz_rd    = nd_rdata[SIZE_W-1:0];

  assign a_smaller = sza_r < szb_r;
  assign winner    = a_smaller ? rb_r : ra_r;
  assign loser     = a_smaller ? ra_r : rb_r;
  assign loser_sz  = a_smaller ? sza_r : szb_r;

  always_comb begin
    case (cmd.dir)
      DIR_UP:    nb = SITE_W'({row_r - IDX_W'(1), col_r});
      DIR_DOWN:  nb = SITE_W'({row_r + IDX_W'(1), col_r});
      DIR_LEFT:  nb = SITE_W'({row_r, col_r - IDX_W'(1)});
      default:   nb = SITE_W'({row_r, col_r + IDX_W'(1)});
    endcase
  end

  always_comb begin
    case (cmd.sel)
      OPND_HERE:   opnd = NODE_W'(here);
      OPND_TOP:    opnd = NODE_TOP;
      OPND_BOTTOM: opnd = NODE_BOTTOM;
      default:     opnd = NODE_W'(nb);
    endcase
  end

  always_comb begin
    stat.bad       = bad_r;
    stat.func      = func_r;
    stat.open_rd   = om_rdata;
    stat.root_hit  = (par_rd == node_r);
    stat.same_root = (ra_r == rb_r);
    stat.row_top   = (row_r == '0);
    stat.row_bot   = ({1'b0, row_r} == side_use - SIDE_W'(1));
    stat.nb_valid[DIR_UP]    = (row_r != '0);
    stat.nb_valid[DIR_DOWN]  = ({1'b0, row_r} + SIDE_W'(1) < side_use);
    stat.nb_valid[DIR_LEFT]  = (col_r != '0);
    stat.nb_valid[DIR_RIGHT] = ({1'b0, col_r} + SIDE_W'(1) < side_use);
    stat.clr_done  = (clr_r == NODE_LAST);
  end

  always_comb begin
    func_r_nxt = func_r;
    row_r_nxt  = row_r;
    col_r_nxt  = col_r;
    bad_r_nxt  = bad_r;
    cnt_r_nxt  = cnt_r;
    clr_r_nxt  = clr_r;
    node_r_nxt = node_r;
    ra_r_nxt   = ra_r;
    rb_r_nxt   = rb_r;
    sza_r_nxt  = sza_r;
    szb_r_nxt  = szb_r;
    open_r_nxt = open_r;
    full_r_nxt = full_r;
    perc_r_nxt = perc_r;
    om_we      = 1'b0;
    om_waddr   = here;
    om_wdata   = 1'b0;
    om_raddr   = here;
    nd_we      = 1'b0;
    nd_waddr   = node_r;
    nd_wdata   = '0;
    nd_raddr   = node_r;
    unique case (cmd.op)
      DP_LATCH: begin
        func_r_nxt = in_func;
        row_r_nxt  = in_row;
        col_r_nxt  = in_col;
        bad_r_nxt  = ({1'b0, in_row} >= side_use) || ({1'b0, in_col} >= side_use);
        open_r_nxt = 1'b0;
        full_r_nxt = 1'b0;
      end
      DP_CLR_STEP: begin
        om_we    = ~clr_r[NODE_W-1];
        om_waddr = clr_r[SITE_W-1:0];
        nd_we    = 1'b1;
        nd_waddr = clr_r;
        nd_wdata = {clr_r, SIZE_W'(1)};
        if (clr_r != NODE_LAST) begin
          clr_r_nxt = clr_r + NODE_W'(1);
        end
      end
      DP_RD_OPEN_HERE: om_raddr = here;
      DP_RD_OPEN_NB:   om_raddr = nb;
      DP_SET_OPEN: begin
        om_we     = 1'b1;
        om_wdata  = 1'b1;
        cnt_r_nxt = cnt_r + CNT_W'(1);
      end
      DP_FIND_START: begin
        node_r_nxt = opnd;
        nd_raddr   = opnd;
      end
      DP_FIND_WALK: begin
        if (par_rd == node_r) begin
          if (cmd.dst == SLOT_A) begin
            ra_r_nxt  = node_r;
            sza_r_nxt = sz_rd;
          end else begin
            rb_r_nxt  = node_r;
            szb_r_nxt = sz_rd;
          end
        end else begin
          node_r_nxt = par_rd;
          nd_raddr   = par_rd;
        end
      end
      DP_LINK_LOSER: begin
        nd_we    = 1'b1;
        nd_waddr = loser;
        nd_wdata = {winner, loser_sz};
      end
      DP_LINK_WINNER: begin
        nd_we    = 1'b1;
        nd_waddr = winner;
        nd_wdata = {winner, sza_r + szb_r};
      end
      DP_CAP_OPEN: open_r_nxt = om_rdata;
      DP_CAP_FULL: full_r_nxt = ~bad_r && (ra_r == rb_r);
      DP_CAP_PERC: perc_r_nxt = (ra_r == rb_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_W'(MAX_SIDE);
      cnt_r  <= '0;
      clr_r  <= '0;
    end else if (cfg_we) begin
      side_r <= cfg_grid_side;
      cnt_r  <= '0;
      clr_r  <= '0;
    end else begin
      cnt_r  <= cnt_r_nxt;
      clr_r  <= clr_r_nxt;
    end
    func_r <= func_r_nxt;
    row_r  <= row_r_nxt;
    col_r  <= col_r_nxt;
    bad_r  <= bad_r_nxt;
    node_r <= node_r_nxt;
    ra_r   <= ra_r_nxt;
    rb_r   <= rb_r_nxt;
    sza_r  <= sza_r_nxt;
    szb_r  <= szb_r_nxt;
    open_r <= open_r_nxt;
    full_r <= full_r_nxt;
    perc_r <= perc_r_nxt;
  end

  assign out_site_open      = open_r;
  assign out_site_full      = full_r;
  assign out_open_total     = cnt_r;
  assign out_does_percolate = perc_r;
  assign out_bad_index      = bad_r;

endmodule

`default_nettype wire

FILE: src/gpuf_ctrl.sv
// ----------------------------------------------------------------------------
// gpuf_ctrl
// Sequencer: clearing pass, site open, up to four unions, and the closing
// finds that produce the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gpuf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               cfg_we,
  input  wire gpuf_pkg::dp_stat_t stat,
  output gpuf_pkg::dp_cmd_t       cmd,
  output logic                    busy,
  output logic                    out_valid
);

  import gpuf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_CHECK,
    S_OPEN_RD,
    S_OPEN_EVAL,
    S_PICK,
    S_NB_EVAL,
    S_JOIN_B,
    S_JOIN_CMP,
    S_LINK2,
    S_WALK,
    S_RPT_RD,
    S_RPT_OPEN,
    S_RPT_HERE,
    S_RPT_TOP,
    S_RPT_FULL,
    S_RPT_BOT,
    S_RPT_PERC,
    S_DONE
  } state_t;

  localparam logic [2:0] K_TOP    = 3'd0;
  localparam logic [2:0] K_BOTTOM = 3'd1;
  localparam logic [2:0] K_END    = 3'd6;

  state_t     state_r, state_r_nxt, ret_r, ret_r_nxt;
  slot_t      dst_r, dst_r_nxt;
  logic [2:0] k_r, k_r_nxt;
  logic       busy_r, busy_r_nxt, valid_r, valid_r_nxt;
  dir_t       k_dir;

  assign k_dir = dir_t'(k_r[1:0] + 2'd2);

  always_comb begin
    state_r_nxt = state_r;
    ret_r_nxt   = ret_r;
    dst_r_nxt   = dst_r;
    k_r_nxt     = k_r;
    cmd.op      = DP_NONE;
    cmd.sel     = OPND_HERE;
    cmd.dst     = dst_r;
    cmd.dir     = k_dir;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op      = DP_LATCH;
          state_r_nxt = S_CHECK;
        end
      end
      S_CLEAR: begin
        cmd.op = DP_CLR_STEP;
        if (stat.clr_done) state_r_nxt = S_IDLE;
      end
      S_CHECK: begin
        if (stat.bad) begin
          cmd.op = DP_FIND_START; cmd.sel = OPND_TOP; cmd.dst = SLOT_B;
          dst_r_nxt = SLOT_B; ret_r_nxt = S_RPT_FULL; state_r_nxt = S_WALK;
        end else if (stat.func == FUNC_QUERY) begin
          state_r_nxt = S_RPT_RD;
        end else begin
          state_r_nxt = S_OPEN_RD;
        end
      end
      S_OPEN_RD: begin
        cmd.op      = DP_RD_OPEN_HERE;
        state_r_nxt = S_OPEN_EVAL;
      end
      S_OPEN_EVAL: begin
        if (stat.open_rd) begin
          state_r_nxt = S_RPT_RD;
        end else begin
          cmd.op      = DP_SET_OPEN;
          k_r_nxt     = K_TOP;
          state_r_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (k_r == K_END) begin
          state_r_nxt = S_RPT_RD;
        end else if (k_r == K_TOP || k_r == K_BOTTOM) begin
          if ((k_r == K_TOP) ? stat.row_top : stat.row_bot) begin
            cmd.op = DP_FIND_START; cmd.sel = OPND_HERE; cmd.dst = SLOT_A;
            dst_r_nxt = SLOT_A; ret_r_nxt = S_JOIN_B; state_r_nxt = S_WALK;
          end else begin
            k_r_nxt = k_r + 3'd1;
          end
        end else if (stat.nb_valid[k_dir]) begin
          cmd.op      = DP_RD_OPEN_NB;
          state_r_nxt = S_NB_EVAL;
        end else begin
          k_r_nxt = k_r + 3'd1;
        end
      end
      S_NB_EVAL: begin
        if (stat.open_rd) begin
          cmd.op = DP_FIND_START; cmd.sel = OPND_HERE; cmd.dst = SLOT_A;
          dst_r_nxt = SLOT_A; ret_r_nxt = S_JOIN_B; state_r_nxt = S_WALK;
        end else begin
          k_r_nxt     = k_r + 3'd1;
          state_r_nxt = S_PICK;
        end
      end
      S_JOIN_B: begin
        cmd.op  = DP_FIND_START;
        cmd.dst = SLOT_B;
        if (k_r == K_TOP) cmd.sel = OPND_TOP;
        else if (k_r == K_BOTTOM) cmd.sel = OPND_BOTTOM;
        else cmd.sel = OPND_NB;
        dst_r_nxt = SLOT_B; ret_r_nxt = S_JOIN_CMP; state_r_nxt = S_WALK;
      end
      S_JOIN_CMP: begin
        if (stat.same_root) begin
          k_r_nxt     = k_r + 3'd1;
          state_r_nxt = S_PICK;
        end else begin
          cmd.op      = DP_LINK_LOSER;
          state_r_nxt = S_LINK2;
        end
      end
      S_LINK2: begin
        cmd.op      = DP_LINK_WINNER;
        k_r_nxt     = k_r + 3'd1;
        state_r_nxt = S_PICK;
      end
      S_WALK: begin
        cmd.op = DP_FIND_WALK;
        if (stat.root_hit) state_r_nxt = ret_r;
      end
      S_RPT_RD: begin
        cmd.op      = DP_RD_OPEN_HERE;
        state_r_nxt = S_RPT_OPEN;
      end
      S_RPT_OPEN: begin
        cmd.op      = DP_CAP_OPEN;
        state_r_nxt = S_RPT_HERE;
      end
      S_RPT_HERE: begin
        cmd.op = DP_FIND_START; cmd.sel = OPND_HERE; cmd.dst = SLOT_A;
        dst_r_nxt = SLOT_A; ret_r_nxt = S_RPT_TOP; state_r_nxt = S_WALK;
      end
      S_RPT_TOP: begin
        cmd.op = DP_FIND_START; cmd.sel = OPND_TOP; cmd.dst = SLOT_B;
        dst_r_nxt = SLOT_B; ret_r_nxt = S_RPT_FULL; state_r_nxt = S_WALK;
      end
      S_RPT_FULL: begin
        cmd.op      = DP_CAP_FULL;
        state_r_nxt = S_RPT_BOT;
      end
      S_RPT_BOT: begin
        cmd.op = DP_FIND_START; cmd.sel = OPND_BOTTOM; cmd.dst = SLOT_A;
        dst_r_nxt = SLOT_A; ret_r_nxt = S_RPT_PERC; state_r_nxt = S_WALK;
      end
      S_RPT_PERC: begin
        cmd.op      = DP_CAP_PERC;
        state_r_nxt = S_DONE;
      end
      S_DONE: state_r_nxt = S_IDLE;
      default: state_r_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      state_r_nxt = S_CLEAR;
    end
    busy_r_nxt  = (state_r_nxt != S_IDLE);
    valid_r_nxt = (state_r_nxt == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ret_r   <= S_IDLE;
      dst_r   <= SLOT_A;
      k_r     <= K_TOP;
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_r_nxt;
      ret_r   <= ret_r_nxt;
      dst_r   <= dst_r_nxt;
      k_r     <= k_r_nxt;
      busy_r  <= busy_r_nxt;
      valid_r <= valid_r_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

`default_nettype wire
